// ===== design/hmmvd_pkg.sv =====
// Shared constants and controller/datapath interface types for the HMM count and Viterbi decoder.
package hmmvd_pkg;

	localparam int unsigned NUM_PHONEMES_DEF      = 128;
	localparam int unsigned MAX_WORD_LEN_DEF      = 32;
	localparam int unsigned NUM_LETTER_STATES_DEF = 27;
	localparam int unsigned COUNT_BITS_DEF        = 16;

	localparam int unsigned SCORE_BITS  = 32;
	localparam int unsigned STATE_BITS  = 5;
	localparam int unsigned POS_BITS    = 6;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned IN_TUSER_W  = 2;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic OP_TRAIN  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic                  capture;
		logic                  clear;
		logic                  cnt_rd;
		logic                  cnt_inc;
		logic                  step_begin;
		logic                  issue;
		logic [STATE_BITS-1:0] jdx;
		logic [STATE_BITS-1:0] idx;
		logic                  bl_load;
		logic                  bl_run;
		logic                  norm_we;
		logic                  wpos_inc;
		logic                  set_ovf;
		logic                  find_init;
		logic                  find_step;
		logic                  tb_init;
		logic                  bp_rd;
		logic                  tb_step;
		logic                  emit;
		logic [POS_BITS-1:0]   eidx;
		logic                  finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic train_ok;
		logic is_decode;
		logic word_end;
		logic wpos_full;
		logic pipe_busy;
		logic bl_done;
		logic k_zero;
		logic len_zero;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

// ===== design/hmm_count_and_viterbi_decode.sv =====
// Top level of the HMM letter counter and Viterbi phoneme-to-letter decoder.
//
// Channel  Direction  tdata (low bit up)                    tlast        tuser (low bit up)
// s_*      in         prev_letter, letter, phoneme          word_end     operation, word_start
// m_*      out        out_letter                            last_letter  truncated
//
// A training request passes through capture, dispatch, a read and a write of the count table.
// A decoding request passes through capture and dispatch, a multiply-compare for each of the
// 27 x 27 state pairs through the count table's single read port and one shared multiplier,
// a drain, a bit-length count and a rescaling of the 27 scores; at a word end add a final
// choice over the 27 scores, a traceback and the sending of each letter.
// After reset the count table is cleared one entry a cycle, all 131072 entries at the default
// sizes, while no request is taken. Results wait in an output register while m_tready is low.
module hmm_count_and_viterbi_decode import hmmvd_pkg::*; #(
	parameter int unsigned NUM_PHONEMES      = NUM_PHONEMES_DEF,
	parameter int unsigned MAX_WORD_LEN      = MAX_WORD_LEN_DEF,
	parameter int unsigned NUM_LETTER_STATES = NUM_LETTER_STATES_DEF,
	parameter int unsigned COUNT_BITS        = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // prev_letter, letter, phoneme, zero fill
	input  logic                   s_tlast,
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // operation, word_start
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // out_letter, zero fill
	output logic                   m_tlast,
	output logic                   m_tuser   // truncated
);

	cmd_t       cmd;
	status_t    status;
	logic [4:0] out_letter;

	hmmvd_ctrl #(
		.NUM_LETTER_STATES(NUM_LETTER_STATES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hmmvd_datapath #(
		.NUM_PHONEMES     (NUM_PHONEMES),
		.MAX_WORD_LEN     (MAX_WORD_LEN),
		.NUM_LETTER_STATES(NUM_LETTER_STATES),
		.COUNT_BITS       (COUNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_tuser[0]),
		.in_prev    (s_tdata[4:0]),
		.in_letter  (s_tdata[9:5]),
		.in_phoneme (s_tdata[16:10]),
		.in_ws      (s_tuser[1]),
		.in_we      (s_tlast),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_letter (out_letter),
		.out_last   (m_tlast),
		.out_trunc  (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'(out_letter);

	logic unused_tdata;
	assign unused_tdata = ^s_tdata[IN_TDATA_W-1:17];

endmodule

// ===== design/hmmvd_datapath.sv =====
// Datapath: count and back pointer memories, scores, multiplier, normaliser and traceback.
module hmmvd_datapath import hmmvd_pkg::*; #(
	parameter int unsigned NUM_PHONEMES      = NUM_PHONEMES_DEF,
	parameter int unsigned MAX_WORD_LEN      = MAX_WORD_LEN_DEF,
	parameter int unsigned NUM_LETTER_STATES = NUM_LETTER_STATES_DEF,
	parameter int unsigned COUNT_BITS        = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_op,
	input  logic [4:0]            in_prev,
	input  logic [4:0]            in_letter,
	input  logic [6:0]            in_phoneme,
	input  logic                  in_ws,
	input  logic                  in_we,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [4:0]            out_letter,
	output logic                  out_last,
	output logic                  out_trunc
);

	localparam int unsigned LW     = $clog2(NUM_LETTER_STATES);
	localparam int unsigned PHW    = $clog2(NUM_PHONEMES);
	localparam int unsigned PSW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int unsigned WPW    = $clog2(MAX_WORD_LEN + 1);
	localparam int unsigned CAW    = 2 * LW + PHW;
	localparam int unsigned CDEPTH = 1 << CAW;
	localparam int unsigned BAW    = PSW + LW;
	localparam int unsigned BDEPTH = 1 << BAW;
	localparam int unsigned PRW    = SCORE_BITS + COUNT_BITS;
	localparam int unsigned BLW    = $clog2(PRW + 1);

	logic                  op_q, ws_q, we_q;
	logic [4:0]            prev_q, letter_q;
	logic [6:0]            ph_q;
	logic [8:0]            ph9;
	logic                  ph_ok;
	logic [PHW-1:0]        ph_a;

	logic [COUNT_BITS-1:0] cnt_mem [CDEPTH];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [CAW-1:0]        cnt_raddr, cnt_waddr, train_addr, clr_q;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic                  cnt_we, cnt_re;

	logic [SCORE_BITS-1:0] score_q [NUM_LETTER_STATES];
	logic [SCORE_BITS-1:0] score_rd;
	logic [LW-1:0]         sc_idx;
	logic [PRW-1:0]        prod_q [NUM_LETTER_STATES];

	logic                  v_s1, v_s2;
	logic [LW-1:0]         j_s1, s_s1, j_s2, s_s2;
	logic [PRW-1:0]        p_s2;
	logic [PRW-1:0]        best_q, nbest;
	logic [LW-1:0]         arg_q, narg;
	logic [PRW-1:0]        m_q, mtmp_q, shifted;
	logic [BLW-1:0]        bl_q;

	logic [4:0]            bp_mem [BDEPTH];
	logic [4:0]            bp_rd_q;
	logic                  bp_we;

	logic [WPW-1:0]        wpos_q, k_q;
	logic                  ovf_q;
	logic                  start;
	logic [LW-1:0]         cur_q;
	logic [SCORE_BITS-1:0] fbest_q;
	logic [LW-1:0]         lbuf [MAX_WORD_LEN];
	logic [PSW-1:0]        lb_widx;
	logic [LW-1:0]         lb_wdata;
	logic                  lb_we;
	logic [WPW-1:0]        wpos_m1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			prev_q   <= in_prev;
			letter_q <= in_letter;
			ph_q     <= in_phoneme;
			ws_q     <= in_ws;
			we_q     <= in_we;
		end
	end

	assign ph9        = 9'(ph_q);
	assign ph_ok      = ph9 < 9'(NUM_PHONEMES);
	assign ph_a       = ph9[PHW-1:0];
	assign train_addr = {prev_q[LW-1:0], letter_q[LW-1:0], ph_a};

	// Count table, one write and one registered read per cycle.
	assign cnt_re    = cmd.issue | cmd.cnt_rd;
	assign cnt_raddr = cmd.issue ? {cmd.jdx[LW-1:0], cmd.idx[LW-1:0], ph_a} : train_addr;
	assign cnt_we    = cmd.clear | cmd.cnt_inc;
	assign cnt_waddr = cmd.clear ? clr_q : train_addr;
	assign cnt_wdata = cmd.clear ? '0 : ((&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Multiply-compare pipeline.
	assign sc_idx   = v_s1 ? j_s1 : cmd.idx[LW-1:0];
	assign score_rd = score_q[sc_idx];
	assign cnt_eff  = ph_ok ? cnt_rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= cmd.jdx[LW-1:0];
		s_s1 <= cmd.idx[LW-1:0];
		j_s2 <= j_s1;
		s_s2 <= s_s1;
		p_s2 <= PRW'(score_rd) * PRW'(cnt_eff);
	end

	always_comb begin
		if ((j_s2 == '0) || (p_s2 > best_q)) begin
			nbest = p_s2;
			narg  = j_s2;
		end else begin
			nbest = best_q;
			narg  = arg_q;
		end
	end

	assign bp_we = v_s2 && (j_s2 == LW'(NUM_LETTER_STATES - 1));

	always_ff @(posedge clk) begin
		if (v_s2) begin
			best_q <= nbest;
			arg_q  <= narg;
		end
		if (bp_we) begin
			prod_q[s_s2] <= nbest;
		end
		if (cmd.step_begin) begin
			m_q <= '0;
		end else if (bp_we && (nbest > m_q)) begin
			m_q <= nbest;
		end
		if (cmd.bl_load) begin
			mtmp_q <= m_q;
			bl_q   <= '0;
		end else if (cmd.bl_run && (mtmp_q != '0)) begin
			mtmp_q <= mtmp_q >> 1;
			bl_q   <= bl_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[{wpos_q[PSW-1:0], s_s2}] <= 5'(narg);
		end
		if (cmd.bp_rd) begin
			bp_rd_q <= bp_mem[{k_q[PSW-1:0], cur_q}];
		end
	end

	always_comb begin
		if (bl_q > BLW'(SCORE_BITS)) begin
			shifted = prod_q[cmd.idx[LW-1:0]] >> (bl_q - BLW'(SCORE_BITS));
		end else begin
			shifted = prod_q[cmd.idx[LW-1:0]] << (BLW'(SCORE_BITS) - bl_q);
		end
	end

	// Scores and word bookkeeping.
	assign start = cmd.finish || (cmd.capture && (in_op == OP_DECODE) && in_ws);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTER_STATES; i++) begin
				score_q[i] <= (i == 0) ? SCORE_BITS'(1) : '0;
			end
			wpos_q <= '0;
			ovf_q  <= 1'b0;
		end else if (start) begin
			for (int i = 0; i < NUM_LETTER_STATES; i++) begin
				score_q[i] <= (i == 0) ? SCORE_BITS'(1) : '0;
			end
			wpos_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.norm_we) begin
				score_q[cmd.idx[LW-1:0]] <= shifted[SCORE_BITS-1:0];
			end
			if (cmd.wpos_inc) begin
				wpos_q <= wpos_q + 1'b1;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Final choice and traceback.
	assign wpos_m1 = wpos_q - 1'b1;

	always_comb begin
		lb_we    = cmd.tb_init | cmd.tb_step;
		lb_widx  = cmd.tb_init ? wpos_m1[PSW-1:0] : PSW'(k_q - 1'b1);
		lb_wdata = cmd.tb_init ? cur_q : bp_rd_q[LW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.find_init) begin
			fbest_q <= score_rd;
			cur_q   <= '0;
		end else if (cmd.find_step && (score_rd > fbest_q)) begin
			fbest_q <= score_rd;
			cur_q   <= cmd.idx[LW-1:0];
		end else if (cmd.tb_step) begin
			cur_q <= bp_rd_q[LW-1:0];
		end
		if (cmd.tb_init) begin
			k_q <= wpos_m1;
		end else if (cmd.tb_step) begin
			k_q <= k_q - 1'b1;
		end
		if (lb_we) begin
			lbuf[lb_widx] <= lb_wdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_letter <= 5'(lbuf[cmd.eidx[PSW-1:0]]);
			out_last   <= status.emit_last;
			out_trunc  <= ovf_q;
		end
	end

	always_comb begin
		status.clear_done = &clr_q;
		status.train_ok   = (6'(prev_q) < 6'(NUM_LETTER_STATES))
			&& (6'(letter_q) < 6'(NUM_LETTER_STATES)) && ph_ok;
		status.is_decode  = (op_q == OP_DECODE);
		status.word_end   = we_q;
		status.wpos_full  = (wpos_q == WPW'(MAX_WORD_LEN));
		status.pipe_busy  = v_s1 | v_s2;
		status.bl_done    = (mtmp_q == '0);
		status.k_zero     = (k_q == '0);
		status.len_zero   = (wpos_q == '0);
		status.emit_last  = (7'(cmd.eidx) == 7'(wpos_m1));
		status.out_free   = !out_valid || out_ready;
	end

	logic unused_ws;
	assign unused_ws = ws_q;

endmodule

// ===== design/hmmvd_ctrl.sv =====
// Controller state machine that clears the count table and sequences training, Viterbi steps, traceback and output.
module hmmvd_ctrl import hmmvd_pkg::*; #(
	parameter int unsigned NUM_LETTER_STATES = NUM_LETTER_STATES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int unsigned LW = $clog2(NUM_LETTER_STATES);
	localparam logic [LW-1:0] LAST_STATE = LW'(NUM_LETTER_STATES - 1);

	typedef enum logic [13:0] {
		ST_CLEAR    = 14'b00000000000001,
		ST_IDLE     = 14'b00000000000010,
		ST_DISPATCH = 14'b00000000000100,
		ST_TRAIN_RD = 14'b00000000001000,
		ST_TRAIN_WR = 14'b00000000010000,
		ST_STEP     = 14'b00000000100000,
		ST_DRAIN    = 14'b00000001000000,
		ST_BITLEN   = 14'b00000010000000,
		ST_NORM     = 14'b00000100000000,
		ST_FIND     = 14'b00001000000000,
		ST_TB_INIT  = 14'b00010000000000,
		ST_TB_RD    = 14'b00100000000000,
		ST_TB_WR    = 14'b01000000000000,
		ST_EMIT     = 14'b10000000000000
	} state_t;

	state_t              state_q, state_d;
	logic [LW-1:0]       j_q, j_d, s_q, s_d;
	logic [POS_BITS-1:0] e_q, e_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			j_q     <= '0;
			s_q     <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			s_q     <= s_d;
			e_q     <= e_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		s_d     = s_q;
		e_d     = e_q;
		cmd     = '0;
		cmd.jdx = STATE_BITS'(j_q);
		cmd.idx = STATE_BITS'(s_q);
		cmd.eidx = e_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				j_d = '0;
				s_d = '0;
				if (!status.is_decode) begin
					state_d = status.train_ok ? ST_TRAIN_RD : ST_IDLE;
				end else if (status.wpos_full) begin
					cmd.set_ovf = 1'b1;
					state_d     = status.word_end ? ST_FIND : ST_IDLE;
				end else begin
					cmd.step_begin = 1'b1;
					state_d        = ST_STEP;
				end
			end
			ST_TRAIN_RD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_TRAIN_WR;
			end
			ST_TRAIN_WR: begin
				cmd.cnt_inc = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_STEP: begin
				cmd.issue = 1'b1;
				if (j_q == LAST_STATE) begin
					j_d = '0;
					s_d = s_q + 1'b1;
					if (s_q == LAST_STATE) begin
						s_d     = '0;
						state_d = ST_DRAIN;
					end
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.bl_load = 1'b1;
					state_d     = ST_BITLEN;
				end
			end
			ST_BITLEN: begin
				cmd.bl_run = 1'b1;
				if (status.bl_done) begin
					s_d     = '0;
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				cmd.norm_we = 1'b1;
				if (s_q == LAST_STATE) begin
					cmd.wpos_inc = 1'b1;
					s_d          = '0;
					state_d      = status.word_end ? ST_FIND : ST_IDLE;
				end else begin
					s_d = s_q + 1'b1;
				end
			end
			ST_FIND: begin
				if (s_q == '0) begin
					cmd.find_init = 1'b1;
				end else begin
					cmd.find_step = 1'b1;
				end
				if (s_q == LAST_STATE) begin
					s_d = '0;
					if (status.len_zero) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_TB_INIT;
					end
				end else begin
					s_d = s_q + 1'b1;
				end
			end
			ST_TB_INIT: begin
				cmd.tb_init = 1'b1;
				state_d     = ST_TB_RD;
			end
			ST_TB_RD: begin
				if (status.k_zero) begin
					e_d     = '0;
					state_d = ST_EMIT;
				end else begin
					cmd.bp_rd = 1'b1;
					state_d   = ST_TB_WR;
				end
			end
			ST_TB_WR: begin
				cmd.tb_step = 1'b1;
				state_d     = ST_TB_RD;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.emit_last) begin
						cmd.finish = 1'b1;
						e_d        = '0;
						state_d    = ST_IDLE;
					end else begin
						e_d = e_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== test/tb_hmm_count_and_viterbi_decode.sv =====
// Self-checking testbench for the HMM count and Viterbi decoder, with its own letter predictor.
`timescale 1ns / 1ps

module tb_hmm_count_and_viterbi_decode;
	import hmmvd_pkg::*;

	localparam int NS        = NUM_LETTER_STATES_DEF;
	localparam int NPH       = NUM_PHONEMES_DEF;
	localparam int WORD_MAX  = MAX_WORD_LEN_DEF;
	localparam int CNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
	localparam int LIMIT     = 3000000;
	localparam int END_WAIT  = 2000;

	typedef struct packed {
		logic [4:0] letter;
		logic       last;
		logic       trunc;
	} letter_res_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	hmm_count_and_viterbi_decode uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	logic [15:0]  hit_count [int];
	logic [31:0]  score [NS];
	logic [4:0]   back_ptr [WORD_MAX][NS];
	int           word_pos;
	logic         dropped;
	letter_res_t  letters_due [$];

	int err_cnt;
	int cycle_cnt;
	int burst_left;
	int hold_left;
	int req_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int cell_idx(int p, int l, int ph);
		return (p * NS + l) * NPH + ph;
	endfunction

	function automatic logic [15:0] count_at(int idx);
		if (hit_count.exists(idx))
			return hit_count[idx];
		return 16'd0;
	endfunction

	task automatic restart_word();
		for (int s = 0; s < NS; s++)
			score[s] = (s == 0) ? 32'd1 : 32'd0;
		word_pos = 0;
		dropped = 1'b0;
	endtask

	task automatic advance_scores(int ph);
		longint unsigned prod [NS];
		longint unsigned best, p, m;
		int arg, bl;
		m = 0;
		for (int s = 0; s < NS; s++) begin
			best = 0;
			arg = 0;
			for (int j = 0; j < NS; j++) begin
				p = longint'(score[j]) * longint'(count_at(cell_idx(j, s, ph)));
				if (p > best) begin
					best = p;
					arg = j;
				end
			end
			prod[s] = best;
			back_ptr[word_pos][s] = arg[4:0];
			if (best > m)
				m = best;
		end
		bl = 0;
		while (bl < 64 && (m >> bl) != 0)
			bl++;
		for (int s = 0; s < NS; s++) begin
			if (m == 0)
				score[s] = 32'd0;
			else if (bl > 32)
				score[s] = 32'(prod[s] >> (bl - 32));
			else
				score[s] = 32'(prod[s] << (32 - bl));
		end
		word_pos++;
	endtask

	task automatic predict_letters(logic op, int prev, int ltr, int ph, logic ws, logic we);
		int cur, idx;
		logic [4:0] path [WORD_MAX];
		letter_res_t r;
		if (op == OP_TRAIN) begin
			if (prev < NS && ltr < NS) begin
				idx = cell_idx(prev, ltr, ph);
				if (count_at(idx) < CNT_MAX)
					hit_count[idx] = count_at(idx) + 16'd1;
			end
			return;
		end
		if (ws)
			restart_word();
		if (word_pos < WORD_MAX)
			advance_scores(ph);
		else
			dropped = 1'b1;
		if (!we)
			return;
		cur = 0;
		for (int s = 1; s < NS; s++)
			if (score[s] > score[cur])
				cur = s;
		if (word_pos > 0) begin
			path[word_pos-1] = cur[4:0];
			for (int k = word_pos - 1; k >= 1; k--) begin
				cur = back_ptr[k][cur % NS];
				path[k-1] = cur[4:0];
			end
		end
		for (int k = 0; k < word_pos; k++) begin
			r.letter = path[k];
			r.last = (k + 1 == word_pos);
			r.trunc = dropped;
			letters_due = {letters_due, r};
		end
		restart_word();
	endtask

	task automatic send_req(logic op, int prev, int ltr, int ph, logic ws, logic we);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, ph[6:0], ltr[4:0], prev[4:0]};
		s_tlast <= we;
		s_tuser <= {ws, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_letters(op, prev, ltr, ph, ws, we);
		req_cnt++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (letters_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		letter_res_t want;
		if (m_tvalid && m_tready) begin
			if (letters_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected letter %0d last %0b trunc %0b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = letters_due.pop_front();
				if (m_tdata !== {3'd0, want.letter} || m_tlast !== want.last ||
						m_tuser !== want.trunc) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("letter mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
							want.letter, want.last, want.trunc, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (cycle_cnt[9:7] == 3'd0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= (cycle_cnt[5:4] != 2'd1) && ($urandom_range(0, 2) != 0);
		end
	end

	task automatic send_word(int len, int ph_hi, logic ws_first);
		for (int k = 0; k < len; k++)
			send_req(OP_DECODE, $urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(0, ph_hi), (k == 0) && ws_first, k == len - 1);
	endtask

	task automatic test_train_edges();
		send_req(OP_TRAIN, 0, 1, 0, 1'b0, 1'b0);
		send_req(OP_TRAIN, 26, 26, 127, 1'b1, 1'b1);
		send_req(OP_TRAIN, 0, 26, 1, 1'b0, 1'b0);
		send_req(OP_TRAIN, 26, 1, 1, 1'b0, 1'b0);
		send_req(OP_TRAIN, 31, 5, 1, 1'b0, 1'b0);
		send_req(OP_TRAIN, 3, 31, 1, 1'b1, 1'b0);
		send_req(OP_TRAIN, 27, 27, 2, 1'b0, 1'b1);
		send_req(OP_TRAIN, 0, 0, 2, 1'b0, 1'b0);
		send_req(OP_TRAIN, 0, 3, 2, 1'b0, 1'b0);
		send_req(OP_TRAIN, 0, 3, 2, 1'b0, 1'b0);
	endtask

	task automatic test_decode_edges();
		send_req(OP_DECODE, 0, 0, 1, 1'b1, 1'b0);
		send_req(OP_DECODE, 31, 31, 1, 1'b0, 1'b1);
		send_req(OP_DECODE, 0, 0, 2, 1'b1, 1'b1);
		send_req(OP_DECODE, 0, 0, 100, 1'b1, 1'b1);
		send_req(OP_DECODE, 0, 0, 127, 1'b0, 1'b0);
		send_req(OP_DECODE, 0, 0, 0, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_word_overflow();
		send_word(WORD_MAX + 2, 3, 1'b1);
		drain();
	endtask

	task automatic test_output_stall();
		hold_left = 3000;
		send_word(2, 3, 1'b1);
		send_word(WORD_MAX, 3, 1'b1);
		send_word(4, 3, 1'b1);
		send_req(OP_TRAIN, 0, 2, 3, 1'b0, 1'b0);
		drain();
	endtask

	task automatic test_random(int n);
		int wl, prev, ltr;
		while (req_cnt < n) begin
			if ($urandom_range(0, 9) < 7) begin
				wl = $urandom_range(1, 6);
				prev = 0;
				for (int k = 0; k < wl; k++) begin
					ltr = $urandom_range(1, 26);
					send_req(OP_TRAIN, prev, ltr, $urandom_range(0, 15),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					prev = ltr;
				end
			end else if ($urandom_range(0, 9) < 8) begin
				send_word($urandom_range(1, 5), 15, $urandom_range(0, 7) != 0);
			end else begin
				send_req(1'($urandom_range(0, 1)), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 127),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		err_cnt = 0;
		cycle_cnt = 0;
		burst_left = 0;
		hold_left = 0;
		req_cnt = 0;
		restart_word();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_train_edges();
		test_decode_edges();
		test_word_overflow();
		test_output_stall();
		test_random(450);
		drain();
		repeat (END_WAIT) @(posedge clk);
		if (err_cnt == 0 && letters_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
